// ----- rtl/differential_drive_odometry_core_macros.svh -----
// ----------------------------------------------------------------------------
// Odometry core assertion macros
// Concurrent assertion shorthands used by the port checker.
// ----------------------------------------------------------------------------
`ifndef DIFFERENTIAL_DRIVE_ODOMETRY_CORE_MACROS_SVH
`define DIFFERENTIAL_DRIVE_ODOMETRY_CORE_MACROS_SVH

// Same-cycle implication, off while reset is asserted.
`define DDO_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("ddo check failed");

// Next-cycle implication, off while reset is asserted.
`define DDO_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("ddo check failed");

// Same-cycle implication, checked through reset as well.
`define DDO_ASSERT_ALWAYS(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) (ante) |-> (cons)) \
        else $error("ddo check failed");

`endif

// ----- rtl/ddo_pkg.sv -----
// ----------------------------------------------------------------------------
// Odometry core package
// Request and result types, sequencer codes and saturation helpers.
// ----------------------------------------------------------------------------
package ddo_pkg;

    localparam int FRAC_BITS = 16;

    // Divider dividend: 33-bit wheel difference magnitude shifted by FRAC_BITS.
    // Also covers |step| * 1000 (below 2^41) for every FRAC_BITS >= 8.
    localparam int DIVD_W = 33 + FRAC_BITS;
    localparam int CNT_W  = $clog2(DIVD_W);
    localparam int PROD_W = 64;

    localparam logic [31:0] DPP_RESET = 32'd65536;
    localparam logic [31:0] WB_RESET  = 32'd6553600;
    localparam logic [31:0] MS_SCALE  = 32'd1000;

    localparam logic CMD_UPDATE = 1'b0;
    localparam logic CMD_CLEAR  = 1'b1;

    localparam logic CFG_DPP = 1'b0;
    localparam logic CFG_WB  = 1'b1;

    typedef struct packed {
        logic               command;
        logic signed [15:0] left_count;
        logic signed [15:0] right_count;
        logic        [15:0] elapsed_ms;
    } t_in_req;

    typedef struct packed {
        logic signed [31:0] left_step;
        logic signed [31:0] right_step;
        logic signed [47:0] left_total;
        logic signed [47:0] right_total;
        logic signed [47:0] linear_travel;
        logic signed [31:0] heading;
        logic signed [31:0] left_speed;
        logic signed [31:0] right_speed;
        logic signed [31:0] linear_speed;
        logic signed [31:0] angular_speed;
    } t_out_req;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL_L,
        S_MUL_R,
        S_SAT_R,
        S_ACCUM,
        S_TRAVEL,
        S_DIV_SET,
        S_DIV_RUN,
        S_DIV_END,
        S_SPD_MUL,
        S_DONE
    } t_state;

    typedef enum logic [2:0] {
        OP_ANG,
        OP_LSPD,
        OP_RSPD,
        OP_LINSPD,
        OP_ANGSPD
    } t_op;

    // Signed magnitude to a 32-bit two's complement value, saturated.
    function automatic logic [31:0] sat_mag32(input logic neg, input logic [PROD_W-1:0] mag);
        logic [31:0] res;
        if (neg) begin
            if (mag > PROD_W'(64'h8000_0000)) res = 32'h8000_0000;
            else res = ~mag[31:0] + 32'd1;
        end else begin
            if (mag > PROD_W'(64'h7FFF_FFFF)) res = 32'h7FFF_FFFF;
            else res = mag[31:0];
        end
        return res;
    endfunction

    function automatic logic [47:0] sat_add48(input logic [47:0] a, input logic [31:0] b);
        logic [48:0] sum;
        logic [47:0] res;
        sum = {a[47], a} + {{17{b[31]}}, b};
        if (sum[48] != sum[47]) res = sum[48] ? 48'h8000_0000_0000 : 48'h7FFF_FFFF_FFFF;
        else res = sum[47:0];
        return res;
    endfunction

    function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] sum;
        logic [31:0] res;
        sum = {a[31], a} + {b[31], b};
        if (sum[32] != sum[31]) res = sum[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        else res = sum[31:0];
        return res;
    endfunction

endpackage

// ----- rtl/differential_drive_odometry_core.sv -----
// ----------------------------------------------------------------------------
// Differential-drive odometry core
// Wheel steps, saturating pose accumulation and speeds in fixed point.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in_data) carries one request:
//   a command, both signed encoder counts and the elapsed milliseconds.
//   Output channel (o_out_valid / i_out_stall / o_out_data) returns exactly
//   one result per request. Write distance_per_pulse (index 0) and wheel_base
//   (index 1) through i_cfg_we / i_cfg_idx / i_cfg_data while idle.
//   An update request passes from accept through the multiplier, the
//   accumulators and the divider to the result; a clear request goes
//   straight to the result. One request is worked on at a time and the
//   next one is accepted from the cycle after the result registers. The
//   update time is set by the shared restoring divider, one quotient bit per
//   cycle, run five times: heading step plus four speeds. A shared 32x32
//   multiplier forms the wheel steps and the step * 1000 products.
//   Reset (synchronous, active low) zeroes counts, totals and heading, loads
//   the register defaults, empties the output register and stalls the input.
//   A stalled result holds in the output register; the next request is still
//   accepted and computed, and waits in the final state until the register
//   frees up.
// ----------------------------------------------------------------------------
module differential_drive_odometry_core
    import ddo_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    input  t_in_req  i_in_data,
    output logic     o_out_valid,
    input  logic     i_out_stall,
    output t_out_req o_out_data,
    input  logic     i_cfg_we,
    input  logic     i_cfg_idx,
    input  logic [31:0] i_cfg_data
);

    t_state r_state, n_state;
    t_op    r_op;

    // Configuration registers
    logic [31:0] r_dpp;
    logic [31:0] r_wb;

    // Request and persistent pose state
    t_in_req     r_req;
    logic [15:0] r_last_l;
    logic [15:0] r_last_r;
    logic [47:0] r_lacc;
    logic [47:0] r_racc;
    logic [47:0] r_tacc;
    logic [31:0] r_head;

    // Per-request results
    logic [31:0] r_ls, r_rs, r_lin, r_ang;
    logic [31:0] r_lsp, r_rsp, r_linsp, r_angsp;

    // Shared multiplier
    logic [31:0]       mul_a;
    logic [31:0]       mul_b;
    logic              mul_neg;
    logic [PROD_W-1:0] mul_p;
    logic [PROD_W-1:0] r_prod;
    logic              r_psign;

    // Shared divider
    logic [DIVD_W-1:0] r_quo;
    logic [31:0]       r_rem;
    logic [31:0]       r_dvs;
    logic              r_dsign;
    logic [CNT_W-1:0]  r_cnt;
    logic [32:0]       div_shift;
    logic [32:0]       div_trial;
    logic              div_qbit;
    logic [DIVD_W-1:0] div_dvd_sel;
    logic [31:0]       div_dvs_sel;
    logic              div_sign_sel;
    logic [31:0]       div_res;

    logic [16:0] dl, dr, dl_abs, dr_abs;
    logic [32:0] lin_sum, diff, diff_abs;
    logic [31:0] spd_num;

    t_out_req r_out;
    logic     r_out_valid;
    logic     in_accept;
    logic     out_free;

    // Hold off requests during reset and while a request is in progress
    assign o_in_stall  = !i_rst_n || (r_state != S_IDLE);
    assign in_accept   = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign out_free    = !r_out_valid || !i_out_stall;

    // Count differences, no wraparound
    assign dl     = {r_req.left_count[15], r_req.left_count} - {r_last_l[15], r_last_l};
    assign dr     = {r_req.right_count[15], r_req.right_count} - {r_last_r[15], r_last_r};
    assign dl_abs = dl[16] ? (~dl + 17'd1) : dl;
    assign dr_abs = dr[16] ? (~dr + 17'd1) : dr;

    assign lin_sum  = {r_ls[31], r_ls} + {r_rs[31], r_rs};
    assign diff     = {r_rs[31], r_rs} - {r_ls[31], r_ls};
    assign diff_abs = diff[32] ? (~diff + 33'd1) : diff;

    // Numerator of the current speed
    always_comb begin
        case (r_op)
            OP_LSPD:   spd_num = r_ls;
            OP_RSPD:   spd_num = r_rs;
            OP_LINSPD: spd_num = r_lin;
            OP_ANGSPD: spd_num = r_ang;
            default:   spd_num = r_ang;
        endcase
    end

    // Multiplier operand select: wheel count delta or speed numerator
    always_comb begin
        case (r_state)
            S_MUL_L: begin
                mul_a   = {15'd0, dl_abs};
                mul_neg = dl[16];
            end
            S_MUL_R: begin
                mul_a   = {15'd0, dr_abs};
                mul_neg = dr[16];
            end
            default: begin
                mul_a   = spd_num[31] ? (~spd_num + 32'd1) : spd_num;
                mul_neg = spd_num[31];
            end
        endcase
    end

    // Second operand: time scale for speeds, pulse scale for wheel steps
    assign mul_b = (r_state == S_SPD_MUL) ? MS_SCALE : r_dpp;
    assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

    // Divider operand select: heading step or speed
    always_comb begin
        if (r_op == OP_ANG) begin
            div_dvd_sel  = {diff_abs, {FRAC_BITS{1'b0}}};
            div_dvs_sel  = r_wb;
            div_sign_sel = diff[32];
        end else begin
            div_dvd_sel  = r_prod[DIVD_W-1:0];
            div_dvs_sel  = {16'd0, r_req.elapsed_ms};
            div_sign_sel = r_psign;
        end
    end

    assign div_shift = {r_rem, r_quo[DIVD_W-1]};
    assign div_trial = div_shift - {1'b0, r_dvs};
    assign div_qbit  = (div_shift >= {1'b0, r_dvs});
    assign div_res   = sat_mag32(r_dsign, PROD_W'(r_quo));

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else r_state <= n_state;
    end

    // Sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_state = (i_in_data.command == CMD_CLEAR) ? S_DONE : S_MUL_L;
                end
            end
            S_MUL_L:   n_state = S_MUL_R;
            S_MUL_R:   n_state = S_SAT_R;
            S_SAT_R:   n_state = S_ACCUM;
            S_ACCUM:   n_state = S_TRAVEL;
            S_TRAVEL:  n_state = S_DIV_SET;
            S_DIV_SET: n_state = (div_dvs_sel == 32'd0) ? S_DIV_END : S_DIV_RUN;
            S_DIV_RUN: n_state = (r_cnt == '0) ? S_DIV_END : S_DIV_RUN;
            S_DIV_END: n_state = (r_op == OP_ANGSPD) ? S_DONE : S_SPD_MUL;
            S_SPD_MUL: n_state = S_DIV_SET;
            S_DONE:    n_state = out_free ? S_IDLE : S_DONE;
            default:   n_state = S_IDLE;
        endcase
    end

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dpp <= DPP_RESET;
            r_wb  <= WB_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_DPP: r_dpp <= i_cfg_data;
                CFG_WB:  r_wb  <= i_cfg_data;
                default: r_dpp <= r_dpp;
            endcase
        end
    end

    // Pose state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_l <= '0;
            r_last_r <= '0;
            r_lacc   <= '0;
            r_racc   <= '0;
            r_tacc   <= '0;
            r_head   <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    // Clear drops the pose but keeps the last counts
                    if (in_accept && i_in_data.command == CMD_CLEAR) begin
                        r_lacc <= '0;
                        r_racc <= '0;
                        r_tacc <= '0;
                        r_head <= '0;
                    end
                end
                S_SAT_R: begin
                    r_last_l <= r_req.left_count;
                    r_last_r <= r_req.right_count;
                end
                S_ACCUM: begin
                    r_lacc <= sat_add48(r_lacc, r_ls);
                    r_racc <= sat_add48(r_racc, r_rs);
                end
                S_TRAVEL: r_tacc <= sat_add48(r_tacc, r_lin);
                S_DIV_END: begin
                    if (r_op == OP_ANG) r_head <= sat_add32(r_head, div_res);
                end
                default: r_head <= r_head;
            endcase
        end
    end

    // Datapath: request capture, multiplier, divider, results
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    r_req <= i_in_data;
                    r_op  <= OP_ANG;
                    if (i_in_data.command == CMD_CLEAR) begin
                        r_ls    <= '0;
                        r_rs    <= '0;
                        r_lsp   <= '0;
                        r_rsp   <= '0;
                        r_linsp <= '0;
                        r_angsp <= '0;
                    end
                end
            end
            S_MUL_L: begin
                r_prod  <= mul_p;
                r_psign <= mul_neg;
            end
            S_MUL_R: begin
                r_ls    <= sat_mag32(r_psign, r_prod);
                r_prod  <= mul_p;
                r_psign <= mul_neg;
            end
            S_SAT_R: r_rs <= sat_mag32(r_psign, r_prod);
            S_ACCUM: r_lin <= lin_sum[32:1];
            S_SPD_MUL: begin
                r_prod  <= mul_p;
                r_psign <= mul_neg;
            end
            S_DIV_SET: begin
                r_dvs   <= div_dvs_sel;
                r_dsign <= div_sign_sel;
                r_rem   <= '0;
                r_cnt   <= CNT_W'(DIVD_W - 1);
                // Divide by zero: force a huge quotient so the result saturates
                if (div_dvs_sel == 32'd0) begin
                    r_quo <= (div_dvd_sel != '0) ? '1 : '0;
                end else begin
                    r_quo <= div_dvd_sel;
                end
            end
            S_DIV_RUN: begin
                r_rem <= div_qbit ? div_trial[31:0] : div_shift[31:0];
                r_quo <= {r_quo[DIVD_W-2:0], div_qbit};
                r_cnt <= r_cnt - CNT_W'(1);
            end
            S_DIV_END: begin
                case (r_op)
                    OP_ANG: begin
                        r_ang <= div_res;
                        r_op  <= OP_LSPD;
                    end
                    OP_LSPD: begin
                        r_lsp <= div_res;
                        r_op  <= OP_RSPD;
                    end
                    OP_RSPD: begin
                        r_rsp <= div_res;
                        r_op  <= OP_LINSPD;
                    end
                    OP_LINSPD: begin
                        r_linsp <= div_res;
                        r_op    <= OP_ANGSPD;
                    end
                    OP_ANGSPD: r_angsp <= div_res;
                    default:   r_op    <= OP_ANG;
                endcase
            end
            default: r_op <= r_op;
        endcase
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_DONE && out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && out_free) begin
            r_out.left_step     <= r_ls;
            r_out.right_step    <= r_rs;
            r_out.left_total    <= r_lacc;
            r_out.right_total   <= r_racc;
            r_out.linear_travel <= r_tacc;
            r_out.heading       <= r_head;
            r_out.left_speed    <= r_lsp;
            r_out.right_speed   <= r_rsp;
            r_out.linear_speed  <= r_linsp;
            r_out.angular_speed <= r_angsp;
        end
    end

endmodule

// ----- rtl/ddo_checker.sv -----
// ----------------------------------------------------------------------------
// Odometry core port checker
// Watches the top-level ports for handshake and sequencing slips.
// ----------------------------------------------------------------------------
`include "differential_drive_odometry_core_macros.svh"

module ddo_checker
    import ddo_pkg::*;
(
    input logic     i_clk,
    input logic     i_rst_n,
    input logic     i_in_valid,
    input logic     o_in_stall,
    input logic     o_out_valid,
    input logic     i_out_stall,
    input t_out_req o_out_data
);

    // Result register is empty right after a reset cycle
    `DDO_ASSERT_ALWAYS(a_out_empty_after_rst, !i_rst_n ##1 1'b1, !o_out_valid)

    // An accepted request keeps the block busy in the next cycle
    `DDO_ASSERT_NEXT(a_busy_after_accept, i_in_valid && !o_in_stall, o_in_stall)

    // A new result appears only as a busy block finishes
    `DDO_ASSERT_IMPL(a_result_from_busy, $rose(o_out_valid), $past(o_in_stall))

    // Hold a stalled result
    `DDO_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall,
                     o_out_valid && $stable(o_out_data))

endmodule

bind differential_drive_odometry_core ddo_checker u_ddo_checker (.*);
